// File: rtl/rlvr_pkg.sv
// ----------------------------------------------------------------------------
// rlvr_pkg
// Shared types and constants for the variable-length record ring log.
// ----------------------------------------------------------------------------
package rlvr_pkg;

  localparam int unsigned STORE_BYTES  = 1024;
  localparam int unsigned ADDR_W       = $clog2(STORE_BYTES);
  localparam int unsigned HEADER_BYTES = 4;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_COMMIT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_BAD_READ = 2'd2;

  typedef enum logic [1:0] {
    K_APPEND,
    K_COMMIT,
    K_READ,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [9:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  status;
    logic [9:0]  newest_length;
    logic [8:0]  records_held;
    logic [10:0] bytes_free;
    logic [7:0]  evicted_now;
  } res_t;

endpackage

// File: rtl/ring_log_variable_records.sv
// An append or commit takes longer when it opens a record, an invalid read ends
// sooner, and each evicted record adds a header read via the one read port.
// The back end finishes one command before it takes the next; the 2-deep
// command queue and the output register let each side stall on its own.
// Reset (rst_n, synchronous): empty log, 1024 bytes free; ring contents kept.
// ----------------------------------------------------------------------------
// ring_log_variable_records
// Byte ring log of length-prefixed records with oldest-first eviction.
// ----------------------------------------------------------------------------
module ring_log_variable_records (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic [9:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_status,
  output logic [9:0]  out_newest_length,
  output logic [8:0]  out_records_held,
  output logic [10:0] out_bytes_free,
  output logic [7:0]  out_evicted_now
);

  logic            q_valid, q_pop;
  rlvr_pkg::cmd_t  q_cmd;
  rlvr_pkg::res_t  res;

  rlvr_front u_front (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_opcode, .in_data_byte, .in_read_index,
    .q_valid, .q_cmd, .q_pop
  );

  rlvr_back u_back (
    .clk, .rst_n,
    .q_valid, .q_cmd, .q_pop,
    .out_valid, .out_stall, .out_res(res)
  );

  assign out_read_data     = res.read_data;
  assign out_status        = res.status;
  assign out_newest_length = res.newest_length;
  assign out_records_held  = res.records_held;
  assign out_bytes_free    = res.bytes_free;
  assign out_evicted_now   = res.evicted_now;

endmodule

// File: rtl/rlvr_front.sv
// ----------------------------------------------------------------------------
// rlvr_front
// Takes input transfers, decodes the opcode and queues commands (2 deep).
// ----------------------------------------------------------------------------
module rlvr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_data_byte,
  input  logic [9:0]        in_read_index,
  output logic              q_valid,
  output rlvr_pkg::cmd_t    q_cmd,
  input  logic              q_pop
);

  rlvr_pkg::cmd_t  q_mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  rlvr_pkg::cmd_t  dec_cmd;
  logic            push;

  always_comb begin
    dec_cmd.data = in_data_byte;
    dec_cmd.idx  = in_read_index;
    unique case (in_opcode)
      rlvr_pkg::OP_APPEND: dec_cmd.kind = rlvr_pkg::K_APPEND;
      rlvr_pkg::OP_COMMIT: dec_cmd.kind = rlvr_pkg::K_COMMIT;
      rlvr_pkg::OP_READ:   dec_cmd.kind = rlvr_pkg::K_READ;
      default:             dec_cmd.kind = rlvr_pkg::K_NOP;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/rlvr_back.sv
// ----------------------------------------------------------------------------
// rlvr_back
// Executes queued commands on the byte ring: eviction, append, header write
// and read, then holds the result in the output register.
// ----------------------------------------------------------------------------
module rlvr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  rlvr_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output rlvr_pkg::res_t    out_res
);

  localparam int unsigned AW = rlvr_pkg::ADDR_W;
  localparam logic [AW:0] STORE_CNT = (AW+1)'(rlvr_pkg::STORE_BYTES);
  localparam logic [AW:0] HDR_CNT   = (AW+1)'(rlvr_pkg::HEADER_BYTES);
  localparam logic [AW-1:0] HDR_OFS = AW'(rlvr_pkg::HEADER_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_EV_RD, S_EV_DO, S_HDR, S_RD, S_RD_W, S_DONE
  } state_t;

  typedef enum logic {PH_OPEN, PH_FILL} phase_t;

  logic [7:0] mem [rlvr_pkg::STORE_BYTES];
  logic [7:0] mem_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata;

  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  rlvr_pkg::cmd_t  cmd_r, cmd_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [3:0][7:0] hdr_r, hdr_nxt;
  logic [AW-1:0]   oldest_r, oldest_nxt;
  logic [AW-1:0]   next_free_r, next_free_nxt;
  logic [AW-1:0]   newest_r, newest_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW:0]     free_r, free_nxt;
  logic [8:0]      total_r, total_nxt;
  logic            open_r, open_nxt;
  logic [AW:0]     open_len_r, open_len_nxt;
  logic [AW:0]     comm_len_r, comm_len_nxt;
  logic [7:0]      tally_r, tally_nxt;
  logic [7:0]      rdata_r, rdata_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;
  rlvr_pkg::res_t  out_res_r, out_res_nxt;

  logic [AW:0]     used;
  logic [32:0]     ev_len;
  logic [AW:0]     ev_clamp;

  assign used     = STORE_CNT - free_r;
  assign ev_len   = 33'(rlvr_pkg::HEADER_BYTES) + {1'b0, hdr_r};
  assign ev_clamp = (ev_len > 33'(used)) ? used : ev_len[AW:0];

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    hdr_nxt       = hdr_r;
    oldest_nxt    = oldest_r;
    next_free_nxt = next_free_r;
    newest_nxt    = newest_r;
    wp_nxt        = wp_r;
    free_nxt      = free_r;
    total_nxt     = total_r;
    open_nxt      = open_r;
    open_len_nxt  = open_len_r;
    comm_len_nxt  = comm_len_r;
    tally_nxt     = tally_r;
    rdata_nxt     = rdata_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = wp_r;
    mem_wdata     = cmd_r.data;
    mem_raddr     = oldest_r + AW'(cnt_r[1:0]);

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cmd_nxt    = q_cmd;
          tally_nxt  = 8'd0;
          rdata_nxt  = 8'd0;
          status_nxt = rlvr_pkg::ST_OK;
          cnt_nxt    = 3'd0;
          phase_nxt  = open_r ? PH_FILL : PH_OPEN;
          case (q_cmd.kind)
            rlvr_pkg::K_APPEND: state_nxt = S_CHECK;
            rlvr_pkg::K_COMMIT: state_nxt = open_r ? S_HDR : S_CHECK;
            rlvr_pkg::K_READ:   state_nxt = S_RD;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      S_CHECK: begin
        cnt_nxt = 3'd0;
        if (phase_r == PH_OPEN) begin
          if (free_r < HDR_CNT && total_r != 9'd0) begin
            state_nxt = S_EV_RD;
          end else begin
            free_nxt     = (free_r >= HDR_CNT) ? free_r - HDR_CNT : '0;
            wp_nxt       = next_free_r + HDR_OFS;
            open_len_nxt = '0;
            open_nxt     = 1'b1;
            if (cmd_r.kind == rlvr_pkg::K_APPEND) begin
              phase_nxt = PH_FILL;
            end else begin
              state_nxt = S_HDR;
            end
          end
        end else begin
          if (free_r == '0 && total_r != 9'd0) begin
            state_nxt = S_EV_RD;
          end else if (free_r == '0) begin
            status_nxt = rlvr_pkg::ST_TOO_LONG;
            state_nxt  = S_DONE;
          end else begin
            mem_we       = 1'b1;
            wp_nxt       = wp_r + AW'(1);
            free_nxt     = free_r - (AW+1)'(1);
            open_len_nxt = open_len_r + (AW+1)'(1);
            state_nxt    = S_DONE;
          end
        end
      end
      S_EV_RD: begin
        // read data is registered and arrives in the cycle after its address
        if (cnt_r != 3'd0) begin
          hdr_nxt[cnt_r[1:0] - 2'd1] = mem_q;
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          state_nxt = S_EV_DO;
        end
      end
      S_EV_DO: begin
        oldest_nxt = oldest_r + ev_clamp[AW-1:0];
        free_nxt   = free_r + ev_clamp;
        total_nxt  = total_r - 9'd1;
        if (total_r == 9'd1) begin
          comm_len_nxt = '0;
        end
        if (tally_r != 8'hff) begin
          tally_nxt = tally_r + 8'd1;
        end
        state_nxt = S_CHECK;
      end
      S_HDR: begin
        mem_we    = 1'b1;
        mem_waddr = next_free_r + AW'(cnt_r[1:0]);
        case (cnt_r[1:0])
          2'd0:    mem_wdata = open_len_r[7:0];
          2'd1:    mem_wdata = 8'(open_len_r >> 8);
          default: mem_wdata = 8'd0;
        endcase
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          newest_nxt    = next_free_r;
          next_free_nxt = wp_r;
          if (total_r != 9'h1ff) begin
            total_nxt = total_r + 9'd1;
          end
          comm_len_nxt = open_len_r;
          open_nxt     = 1'b0;
          open_len_nxt = '0;
          state_nxt    = S_DONE;
        end
      end
      S_RD: begin
        mem_raddr = newest_r + HDR_OFS + AW'(cmd_r.idx);
        if (total_r == 9'd0 || (AW+1)'(cmd_r.idx) >= comm_len_r) begin
          status_nxt = rlvr_pkg::ST_BAD_READ;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_RD_W;
        end
      end
      S_RD_W: begin
        rdata_nxt = mem_q;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_res_nxt.read_data     = rdata_r;
          out_res_nxt.status        = status_r;
          out_res_nxt.newest_length = (total_r != 9'd0) ? comm_len_r[9:0] : 10'd0;
          out_res_nxt.records_held  = total_r;
          out_res_nxt.bytes_free    = free_r;
          out_res_nxt.evicted_now   = tally_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_OPEN;
      oldest_r    <= '0;
      next_free_r <= '0;
      newest_r    <= '0;
      wp_r        <= '0;
      free_r      <= STORE_CNT;
      total_r     <= 9'd0;
      open_r      <= 1'b0;
      open_len_r  <= '0;
      comm_len_r  <= '0;
      tally_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      oldest_r    <= oldest_nxt;
      next_free_r <= next_free_nxt;
      newest_r    <= newest_nxt;
      wp_r        <= wp_nxt;
      free_r      <= free_nxt;
      total_r     <= total_nxt;
      open_r      <= open_nxt;
      open_len_r  <= open_len_nxt;
      comm_len_r  <= comm_len_nxt;
      tally_r     <= tally_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r     <= cmd_nxt;
    cnt_r     <= cnt_nxt;
    hdr_r     <= hdr_nxt;
    rdata_r   <= rdata_nxt;
    status_r  <= status_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: rtl/rlvr_checker.sv
// ----------------------------------------------------------------------------
// rlvr_checker
// Port-level checks for the record ring log, bound to the top level.
// ----------------------------------------------------------------------------
module rlvr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_read_data,
  input logic [1:0]  out_status,
  input logic [9:0]  out_newest_length,
  input logic [8:0]  out_records_held,
  input logic [10:0] out_bytes_free
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bytes_free))
    else $error("result changed while stalled");

  a_bad_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rlvr_pkg::ST_BAD_READ |-> out_read_data == 8'd0)
    else $error("invalid read returned data");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bytes_free <= 11'(rlvr_pkg::STORE_BYTES))
    else $error("free count beyond store size");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_records_held == 9'd0 |-> out_newest_length == 10'd0)
    else $error("length reported with no record held");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("unknown status code");

endmodule

bind ring_log_variable_records rlvr_checker u_rlvr_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_read_data, .out_status,
  .out_newest_length, .out_records_held, .out_bytes_free
);
